/* rtl/br1rd_pkg.sv */
// br1rd_pkg: shared constants, types and helpers of the byterun1 row decoder
// no dependencies
package br1rd_pkg;

    localparam int MAX_ROW_BYTES = 8192;
    localparam int ROW_W         = 14;
    localparam int BYTE_W        = 8;
    localparam int CFG_W         = 14;
    localparam int IDX_W         = 1;
    localparam int Q_DEPTH       = 2;
    localparam int QPTR_W        = 1;
    localparam int QCNT_W        = 2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_ROW_LENGTH = 1'b0;
    localparam logic [IDX_W-1:0] REG_COMP_MODE  = 1'b1;

    localparam logic [ROW_W-1:0]  ROW_LENGTH_RST = 14'd40;
    localparam logic              COMP_MODE_RST  = 1'b1;

    // control byte that does nothing
    localparam logic [BYTE_W-1:0] CTRL_NOP = 8'h80;

    // decode command passed from front to back
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic [BYTE_W-1:0] count;
        logic              lit;   // literal byte (or raw byte)
        logic              last;  // last byte of its stream run
    } t_cmd;

    // row length as the decoder uses it: 0 acts as 1, clipped to the max
    function automatic logic [ROW_W-1:0] eff_length(input logic [ROW_W-1:0] len);
        logic [ROW_W-1:0] n;
        n = len;
        if (n == '0) begin
            n = ROW_W'(1);
        end
        if (n > ROW_W'(MAX_ROW_BYTES)) begin
            n = ROW_W'(MAX_ROW_BYTES);
        end
        return n;
    endfunction

endpackage

/* rtl/br1rd_front.sv */
// br1rd_front: stream parser, classifies control, literal and repeat bytes
// depends on br1rd_pkg
module br1rd_front
    import br1rd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_restart,
    input  logic              i_comp_mode,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_push,
    output t_cmd              o_cmd
);

    typedef enum logic [2:0] {
        PH_CONTROL = 3'b001,
        PH_LITERAL = 3'b010,
        PH_REPEAT  = 3'b100
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_run_left, n_run_left;
    logic [BYTE_W:0]   w_rep_len;

    assign w_rep_len = (BYTE_W+1)'(257) - {1'b0, i_byte};

    always_comb begin
        n_phase    = r_phase;
        n_run_left = r_run_left;
        o_push     = 1'b0;
        o_cmd      = '{value: i_byte, count: BYTE_W'(1), lit: 1'b1, last: 1'b1};
        if (i_accept) begin
            if (!i_comp_mode) begin
                // raw copy: every byte is a run of one
                o_push = 1'b1;
            end else begin
                unique case (r_phase)
                    PH_CONTROL: begin
                        if (!i_byte[BYTE_W-1]) begin
                            n_run_left = i_byte + BYTE_W'(1);
                            n_phase    = PH_LITERAL;
                        end else if (i_byte != CTRL_NOP) begin
                            n_run_left = w_rep_len[BYTE_W-1:0];
                            n_phase    = PH_REPEAT;
                        end
                    end
                    PH_LITERAL: begin
                        o_push     = 1'b1;
                        o_cmd.last = (r_run_left == BYTE_W'(1));
                        n_run_left = r_run_left - BYTE_W'(1);
                        if (r_run_left == BYTE_W'(1)) begin
                            n_phase = PH_CONTROL;
                        end
                    end
                    PH_REPEAT: begin
                        o_push      = 1'b1;
                        o_cmd.count = r_run_left;
                        o_cmd.lit   = 1'b0;
                        n_run_left  = '0;
                        n_phase     = PH_CONTROL;
                    end
                    default: begin
                        n_phase = PH_CONTROL;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_phase    <= PH_CONTROL;
            r_run_left <= '0;
        end else begin
            r_phase    <= n_phase;
            r_run_left <= n_run_left;
        end
    end

endmodule

/* rtl/br1rd_queue.sv */
// br1rd_queue: two-entry command queue between front and back
// depends on br1rd_pkg
module br1rd_queue
    import br1rd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_flush,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd              r_mem [Q_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

endmodule

/* rtl/br1rd_back.sv */
// br1rd_back: row accounting, run clipping, literal skip and output register
// depends on br1rd_pkg
module br1rd_back
    import br1rd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_restart,
    input  logic [ROW_W-1:0]  i_restart_len,
    input  logic [ROW_W-1:0]  i_eff_len,
    input  logic              i_q_valid,
    input  t_cmd              i_q_cmd,
    output logic              o_q_pop,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [BYTE_W-1:0] o_out_value,
    output logic [BYTE_W-1:0] o_run_count,
    output logic              o_row_done
);

    logic [ROW_W-1:0]  r_row_left;
    logic              r_skip;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_value;
    logic [BYTE_W-1:0] r_out_count;
    logic              r_out_done;

    logic              w_out_free;
    logic              w_drop;
    logic              w_load;
    logic              w_done;
    logic [BYTE_W-1:0] w_count;

    assign w_out_free = !r_out_valid || !i_out_stall;
    // leftover literal bytes after a row filled mid-run
    assign w_drop     = r_skip && i_q_cmd.lit;
    assign w_load     = i_q_valid && !w_drop && w_out_free;
    assign o_q_pop    = i_q_valid && (w_drop || w_out_free);

    assign w_done  = {{(ROW_W-BYTE_W){1'b0}}, i_q_cmd.count} >= r_row_left;
    assign w_count = w_done ? r_row_left[BYTE_W-1:0] : i_q_cmd.count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_row_left  <= i_restart_len;
            r_skip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_row_left  <= w_done ? i_eff_len : r_row_left - ROW_W'(i_q_cmd.count);
                r_out_valid <= 1'b1;
                if (w_done && i_q_cmd.lit && !i_q_cmd.last) begin
                    r_skip <= 1'b1;
                end
            end else begin
                if (!i_out_stall) begin
                    r_out_valid <= 1'b0;
                end
                if (i_q_valid && w_drop && i_q_cmd.last) begin
                    r_skip <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_value <= i_q_cmd.value;
            r_out_count <= w_count;
            r_out_done  <= w_done;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_run_count = r_out_count;
    assign o_row_done  = r_out_done;

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_count != '0))
        else $error("result with zero run count");

    a_row_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row_left != '0) && (r_row_left <= ROW_W'(MAX_ROW_BYTES)))
        else $error("row remainder out of range");

    a_done_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_done && !i_restart) |=> (r_row_left == $past(i_eff_len)))
        else $error("row remainder not reloaded at row end");

    a_drop_no_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_q_valid && w_drop && !i_restart && r_out_valid && i_out_stall)
            |=> (r_out_valid && $stable(r_out_value)))
        else $error("skipped literal disturbed the output register");

endmodule

/* rtl/byterun1_row_decoder.sv */
// byterun1_row_decoder: top level, configuration registers and the three stages
// depends on br1rd_pkg, br1rd_front, br1rd_queue, br1rd_back
//
// usage
//   input channel  : i_in_valid / o_in_stall / i_in_byte, one stream byte per item
//   output channel : o_out_valid / i_out_stall / o_out_value, o_run_count, o_row_done
//   an item moves at a rising edge with valid high and stall low
//   config port    : i_cfg_we, i_cfg_index (0 row length, 1 compressed mode), i_cfg_data
//   any config write restarts decoding: control byte expected, fresh row
// timing
//   one byte per cycle sustained unless the output stalls; the front parser
//   updates its small run counter each cycle, the back stage does one row
//   subtract and compare; a data byte's result passes the queue, then the
//   output register; control bytes and skipped literal leftovers give no result item
// reset
//   synchronous, active low: row length 40, compressed mode, queue and output empty
// stall
//   o_in_stall rises only when the two-entry queue is full; a stalled result
//   holds in the output register while the front keeps filling the queue
module byterun1_row_decoder
    import br1rd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // stream bytes in
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BYTE_W-1:0] i_in_byte,
    // decoded runs out
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [BYTE_W-1:0] o_out_value,
    output logic [BYTE_W-1:0] o_run_count,
    output logic              o_row_done,
    // configuration writes
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    // configuration registers
    logic [ROW_W-1:0] r_row_length, n_row_length;
    logic             r_comp_mode, n_comp_mode;

    logic             w_in_accept;
    logic             w_push;
    t_cmd             w_push_cmd;
    logic             w_q_full;
    logic             w_q_valid;
    t_cmd             w_q_cmd;
    logic             w_q_pop;

    always_comb begin
        n_row_length = r_row_length;
        n_comp_mode  = r_comp_mode;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ROW_LENGTH: n_row_length = i_cfg_data[ROW_W-1:0];
                REG_COMP_MODE:  n_comp_mode  = i_cfg_data[0];
                default:        n_row_length = r_row_length;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= ROW_LENGTH_RST;
            r_comp_mode  <= COMP_MODE_RST;
        end else begin
            r_row_length <= n_row_length;
            r_comp_mode  <= n_comp_mode;
        end
    end

    // only a full queue holds off the input
    assign o_in_stall  = w_q_full;
    assign w_in_accept = i_in_valid && !w_q_full;

    br1rd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (i_cfg_we),
        .i_comp_mode (r_comp_mode),
        .i_accept    (w_in_accept),
        .i_byte      (i_in_byte),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd)
    );

    br1rd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flush (i_cfg_we),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    // restart length taken from the value being written, so the new row
    // starts at the same edge as the write; reset loads the reset length
    br1rd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_restart     (i_cfg_we),
        .i_restart_len (i_rst_n ? eff_length(n_row_length) : eff_length(ROW_LENGTH_RST)),
        .i_eff_len     (eff_length(r_row_length)),
        .i_q_valid     (w_q_valid),
        .i_q_cmd       (w_q_cmd),
        .o_q_pop       (w_q_pop),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_value   (o_out_value),
        .o_run_count   (o_run_count),
        .o_row_done    (o_row_done)
    );

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// testbench: self-checking bench for byterun1_row_decoder, packbits decode of one byte per item
// depends on br1rd_pkg and the byterun1_row_decoder rtl; predicts every run and compares it
module testbench;
    import br1rd_pkg::*;

    // decode phases of the predictor
    typedef enum logic [1:0] {
        PH_CTRL,
        PH_LIT,
        PH_REP,
        PH_SKIP
    } t_dec_phase;

    // one decoded run as the block reports it
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic [BYTE_W-1:0] count;
        logic              done;
    } t_run;

    // one entry of the stimulus stream: a byte item or a register write
    typedef struct packed {
        logic              is_write;
        logic [IDX_W-1:0]  idx;
        logic [CFG_W-1:0]  data;
        logic [BYTE_W-1:0] val;
    } t_stream_entry;

    localparam int SETTLE_CYCLES = 8;      // quiet time before a register write
    localparam int HOLD_CYCLES   = 80;     // long receiver hold-off
    localparam int RAND_ITEMS    = 1050;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic [BYTE_W-1:0] i_in_byte   = '0;
    logic              i_out_stall = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_W-1:0]  i_cfg_data  = '0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic [BYTE_W-1:0] o_out_value;
    logic [BYTE_W-1:0] o_run_count;
    logic              o_row_done;

    byterun1_row_decoder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_byte   (i_in_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_value (o_out_value),
        .o_run_count (o_run_count),
        .o_row_done  (o_row_done),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock, 2 ns period
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // stimulus stream and the runs still owed by the block
    t_stream_entry stream_q[$];
    t_run          expected_runs[$];

    int  items_in    = 0;
    int  runs_seen   = 0;
    int  quiet       = 0;
    int  hold_left   = 0;
    bit  hold_done   = 1'b0;
    bit  failed      = 1'b0;

    // decoder state mirrored by the predictor
    logic [CFG_W-1:0]  reg_row_len;
    logic              reg_comp;
    t_dec_phase        dec_phase;
    logic [BYTE_W-1:0] dec_run_left;
    logic [ROW_W-1:0]  dec_row_left;

    // stretch of the run with no idling on either side
    function automatic bit calm_stretch();
        return items_in >= 400 && items_in < 650;
    endfunction

    // row length as decoded: zero acts as one, anything past the max is clipped
    function automatic logic [ROW_W-1:0] row_span();
        logic [ROW_W-1:0] n;
        n = reg_row_len[ROW_W-1:0];
        if (n == '0) begin
            n = ROW_W'(1);
        end
        if (n > ROW_W'(MAX_ROW_BYTES)) begin
            n = ROW_W'(MAX_ROW_BYTES);
        end
        return n;
    endfunction

    // any register write starts a fresh row waiting for a control byte
    function automatic void restart_row();
        dec_phase    = PH_CTRL;
        dec_run_left = '0;
        dec_row_left = row_span();
    endfunction

    function automatic void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] d);
        if (idx == REG_ROW_LENGTH) begin
            reg_row_len = d;
        end else begin
            reg_comp = d[0];
        end
        restart_row();
    endfunction

    // one run of up to n copies, clipped to what the row still owes
    function automatic t_run emit_run(logic [BYTE_W-1:0] v, logic [BYTE_W-1:0] n);
        t_run r;
        r.value = v;
        r.done  = 1'b0;
        if (dec_row_left == '0) begin
            dec_row_left = row_span();
        end
        if (ROW_W'(n) >= dec_row_left) begin
            r.count      = dec_row_left[BYTE_W-1:0];
            r.done       = 1'b1;
            dec_row_left = row_span();
        end else begin
            r.count      = n;
            dec_row_left = dec_row_left - ROW_W'(n);
        end
        return r;
    endfunction

    // advances the predictor by one byte; returns 1 when a run comes out
    function automatic bit decode_byte(input logic [BYTE_W-1:0] b, output t_run r);
        r = '0;
        if (!reg_comp) begin
            r = emit_run(b, 8'd1);
            return 1'b1;
        end
        case (dec_phase)
            PH_CTRL: begin
                if (b < CTRL_NOP) begin
                    dec_run_left = b + 8'd1;
                    dec_phase    = PH_LIT;
                end else if (b != CTRL_NOP) begin
                    dec_run_left = BYTE_W'(9'd257 - 9'(b));
                    dec_phase    = PH_REP;
                end
                return 1'b0;
            end
            PH_LIT: begin
                r = emit_run(b, 8'd1);
                if (dec_run_left != '0) begin
                    dec_run_left = dec_run_left - 8'd1;
                end
                if (dec_run_left == '0) begin
                    dec_phase = PH_CTRL;
                end else if (r.done) begin
                    // row filled mid literal: the rest of the run is dropped
                    dec_phase = PH_SKIP;
                end
                return 1'b1;
            end
            PH_REP: begin
                r            = emit_run(b, dec_run_left);
                dec_run_left = '0;
                dec_phase    = PH_CTRL;
                return 1'b1;
            end
            default: begin
                if (dec_run_left != '0) begin
                    dec_run_left = dec_run_left - 8'd1;
                end
                if (dec_run_left == '0) begin
                    dec_phase = PH_CTRL;
                end
                return 1'b0;
            end
        endcase
    endfunction

    task automatic add_byte(logic [BYTE_W-1:0] b);
        t_stream_entry e;
        e          = '0;
        e.val      = b;
        stream_q.push_back(e);
    endtask

    task automatic add_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] d);
        t_stream_entry e;
        e          = '0;
        e.is_write = 1'b1;
        e.idx      = idx;
        e.data     = d;
        stream_q.push_back(e);
    endtask

    // well-formed packet: control byte plus its literal or repeat bytes; returns its length
    task automatic add_packet(output int len);
        int k;
        logic [BYTE_W-1:0] ctrl;
        k   = $urandom_range(0, 19);
        len = 1;
        if (k == 0) begin
            ctrl = CTRL_NOP;
        end else if (k < 5) begin
            ctrl = BYTE_W'($urandom_range(0, 7));
        end else if (k < 9) begin
            ctrl = BYTE_W'($urandom_range(0, 127));
        end else begin
            ctrl = BYTE_W'($urandom_range(129, 255));
        end
        add_byte(ctrl);
        if (ctrl < CTRL_NOP) begin
            for (int i = 0; i <= int'(ctrl); i++) begin
                add_byte(BYTE_W'($urandom));
            end
            len += int'(ctrl) + 1;
        end else if (ctrl != CTRL_NOP) begin
            add_byte(BYTE_W'($urandom));
            len += 1;
        end
    endtask

    // driver: presents stream items and register writes, runs the predictor on acceptance
    always @(posedge i_clk) begin : drive_proc
        t_run              r;
        bit                stalled;
        logic              nxt_valid;
        logic [BYTE_W-1:0] nxt_byte;
        logic              nxt_we;
        logic [IDX_W-1:0]  nxt_idx;
        logic [CFG_W-1:0]  nxt_data;
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_cfg_we    <= 1'b0;
            reg_row_len = CFG_W'(ROW_LENGTH_RST);
            reg_comp    = COMP_MODE_RST;
            restart_row();
            quiet       = 0;
        end else begin
            nxt_valid = i_in_valid;
            nxt_byte  = i_in_byte;
            nxt_we    = 1'b0;
            nxt_idx   = i_cfg_index;
            nxt_data  = i_cfg_data;
            stalled   = i_in_valid && o_in_stall;
            if (quiet < SETTLE_CYCLES) begin
                quiet++;
            end
            // item taken at this edge
            if (i_in_valid && !o_in_stall) begin
                if (decode_byte(i_in_byte, r)) begin
                    expected_runs.push_back(r);
                end
                items_in++;
                quiet     = 0;
                nxt_valid = 1'b0;
            end
            if (!stalled && stream_q.size() > 0) begin
                if (stream_q[0].is_write) begin
                    // writes only once the block has drained and gone quiet
                    nxt_valid = 1'b0;
                    if (!i_in_valid && !i_cfg_we && expected_runs.size() == 0
                        && quiet >= SETTLE_CYCLES) begin
                        nxt_we   = 1'b1;
                        nxt_idx  = stream_q[0].idx;
                        nxt_data = stream_q[0].data;
                        write_reg(stream_q[0].idx, stream_q[0].data);
                        void'(stream_q.pop_front());
                        quiet = 0;
                    end
                end else if (!calm_stretch() && $urandom_range(0, 99) < 23) begin
                    nxt_valid = 1'b0;
                end else begin
                    nxt_valid = 1'b1;
                    nxt_byte  = stream_q[0].val;
                    void'(stream_q.pop_front());
                end
            end
            i_in_valid  <= nxt_valid;
            i_in_byte   <= nxt_byte;
            i_cfg_we    <= nxt_we;
            i_cfg_index <= nxt_idx;
            i_cfg_data  <= nxt_data;
        end
    end

    // monitor: takes runs, checks them against the oldest prediction, drives the stall
    always @(posedge i_clk) begin : monitor_proc
        t_run exp_r;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_runs.size() == 0) begin
                    $error("unexpected run: out_value %0h run_count %0d row_done %0b",
                           o_out_value, o_run_count, o_row_done);
                    failed = 1'b1;
                end else begin
                    exp_r = expected_runs.pop_front();
                    if (o_out_value !== exp_r.value) begin
                        $error("out_value: expected %0h, got %0h", exp_r.value, o_out_value);
                        failed = 1'b1;
                    end
                    if (o_run_count !== exp_r.count) begin
                        $error("run_count: expected %0d, got %0d", exp_r.count, o_run_count);
                        failed = 1'b1;
                    end
                    if (o_row_done !== exp_r.done) begin
                        $error("row_done: expected %0b, got %0b", exp_r.done, o_row_done);
                        failed = 1'b1;
                    end
                    runs_seen++;
                end
            end
            // one long hold-off while bytes keep coming, so the input side backs up
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (!hold_done && runs_seen >= 150 && stream_q.size() > 0
                         && !stream_q[0].is_write) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !calm_stretch() && $urandom_range(0, 99) < 23;
            end
        end
    end

    // stimulus fill, reset and end of run
    initial begin : stim_proc
        int n_rand;
        int phase_no;
        int target;
        int cnt;
        int len;
        logic [CFG_W-1:0] row_val;
        logic [CFG_W-1:0] mode_val;

        // directed part, reset settings: row of 40, compressed
        add_byte(CTRL_NOP);                      // no-op control byte
        add_byte(8'h00); add_byte(8'hFF);        // literal of one
        add_byte(8'h81); add_byte(8'h00);        // 128 copies, clipped at row end
        add_byte(8'hFF); add_byte(8'hAA);        // two copies
        add_byte(8'h01); add_byte(8'h55); add_byte(8'h7F);
        // literal overrunning a 3-byte row, leftovers skipped
        add_write(REG_ROW_LENGTH, CFG_W'(3));
        add_byte(8'h05);
        for (int i = 1; i <= 6; i++) begin
            add_byte(BYTE_W'(i));
        end
        add_byte(8'hFE); add_byte(8'h12);
        // raw copy, zero row length acts as one
        add_write(REG_COMP_MODE, CFG_W'(0));
        add_write(REG_ROW_LENGTH, CFG_W'(0));
        add_byte(8'h00); add_byte(8'hFF); add_byte(8'h80);
        // row length past the max
        add_write(REG_ROW_LENGTH, CFG_W'(16383));
        add_byte(8'h7F); add_byte(8'h01);

        // random part: phases of settings, mostly well-formed packets
        n_rand   = 0;
        phase_no = 0;
        while (n_rand < RAND_ITEMS) begin
            case (phase_no)
                0:       row_val = CFG_W'(1);
                1:       row_val = CFG_W'(MAX_ROW_BYTES);
                2:       row_val = CFG_W'(2);
                default: begin
                    case ($urandom_range(0, 9))
                        0:       row_val = '0;
                        1:       row_val = CFG_W'(1);
                        2:       row_val = CFG_W'(MAX_ROW_BYTES);
                        3:       row_val = CFG_W'($urandom_range(MAX_ROW_BYTES + 1, 16383));
                        4:       row_val = CFG_W'($urandom);
                        default: row_val = CFG_W'($urandom_range(3, 48));
                    endcase
                end
            endcase
            // upper data bits are don't-care for the mode register
            mode_val    = CFG_W'($urandom);
            mode_val[0] = (phase_no < 3) || ($urandom_range(0, 9) < 8);
            if ($urandom_range(0, 1)) begin
                add_write(REG_ROW_LENGTH, row_val);
                add_write(REG_COMP_MODE, mode_val);
            end else begin
                add_write(REG_COMP_MODE, mode_val);
                add_write(REG_ROW_LENGTH, row_val);
            end
            target = $urandom_range(40, 120);
            // keep the total close to the planned item count
            if (target > RAND_ITEMS - n_rand) begin
                target = RAND_ITEMS - n_rand;
            end
            cnt    = 0;
            while (cnt < target) begin
                if (!mode_val[0] || $urandom_range(0, 9) == 0) begin
                    add_byte(BYTE_W'($urandom));
                    cnt++;
                end else begin
                    add_packet(len);
                    cnt += len;
                end
            end
            n_rand += cnt;
            phase_no++;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        while (stream_q.size() > 0 || i_in_valid || i_cfg_we || expected_runs.size() > 0) begin
            @(posedge i_clk);
        end
        // let any stray run show up
        repeat (20) @(posedge i_clk);
        if (failed) begin
            $display("Mismatches found");
        end else begin
            $display("No mismatches found");
        end
        $finish;
    end

    // hard limit, far past the slowest correct run
    initial begin : limit_proc
        #400000;
        $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
rtl/br1rd_pkg.sv
rtl/br1rd_front.sv
rtl/br1rd_queue.sv
rtl/br1rd_back.sv
rtl/byterun1_row_decoder.sv
dv/testbench.sv
